FILE: src/radial_stick_dead_zone_top_assert.svh
// ----------------------------------------------------------------------------
// Radial stick dead zone: assertion macros
// Shared concurrent assertion forms used by the block's RTL.
// ----------------------------------------------------------------------------
`ifndef RADIAL_STICK_DEAD_ZONE_TOP_ASSERT_SVH
`define RADIAL_STICK_DEAD_ZONE_TOP_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RSDZ_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsdz assertion failed");

// The condition must never hold.
`define RSDZ_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rsdz assertion failed");

`endif

FILE: src/rsdz_pkg.sv
// ----------------------------------------------------------------------------
// Radial stick dead zone package
// Constants, register reset values and register indexes for the block.
// ----------------------------------------------------------------------------
package rsdz_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int DZ_W            = 15;
   localparam int AXIS_W          = 16;
   // Quotient bits of the normalized axis; all ones stands for 1.0.
   localparam int FRAC_W          = 15;

   localparam logic [DZ_W-1:0] LEFT_DZ_RST  = 15'd7849;
   localparam logic [DZ_W-1:0] RIGHT_DZ_RST = 15'd8689;

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_DZ  = 1'b0,
      CSR_RIGHT_DZ = 1'b1
   } csr_index_type;

endpackage

FILE: src/radial_stick_dead_zone_top.sv
// ----------------------------------------------------------------------------
// Radial stick dead zone, top level
// Thumbstick sample normalization with a per-stick radial dead zone.
// ----------------------------------------------------------------------------
// The block takes one stick sample beat per cycle while the output buffer
// is not full and returns one result beat per sample, in order. Samples
// are SAMPLE_BITS wide, 16-bit by default. The pipeline has three stages
// for absolute value, squaring and summing, one stage per root bit of
// the square root, three stages for the clamp, rescale products and the
// full-scale multiply, fifteen stages of the divider (one per output bit),
// and the output buffer. The magnitude is the floor square root of
// x*x + y*y. At or below the selected stick's dead zone both axes are zero
// and in_dead_zone is set. Otherwise each axis is
// raw * (min(mag, max) - dz) * 32767 / ((max - dz) * mag), truncated toward
// zero, with the sign of the raw axis; a dead zone at or above the largest
// magnitude gives zero axes. A two-beat output buffer lets the pipeline keep
// taking samples while a result waits to be taken. Dead zone registers are
// written through the csr_ port and should be changed only while idle.
// ----------------------------------------------------------------------------
`include "radial_stick_dead_zone_top_assert.svh"

module radial_stick_dead_zone_top
   import rsdz_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Sample input channel.
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_stick_select,
   input  logic signed [SAMPLE_BITS-1:0] req_raw_x,
   input  logic signed [SAMPLE_BITS-1:0] req_raw_y,
   // Result channel.
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [AXIS_W-1:0]      rsp_axis_x,
   output logic signed [AXIS_W-1:0]      rsp_axis_y,
   output logic                          rsp_in_dead_zone,
   // Register write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [DZ_W-1:0]               csr_wdata
);

   localparam int SB      = SAMPLE_BITS;
   localparam int SQ_W    = 2 * SB;
   localparam int FR_W    = SB - 1;
   localparam int CMP_W   = SB + DZ_W;
   localparam int PROD_W  = SB + FR_W;
   localparam int NUM_W   = PROD_W + FRAC_W;
   localparam int STAG_W  = 2 * SB + 2 + DZ_W;
   localparam int DTAG_W  = 4;
   localparam int WORD_W  = 2 * AXIS_W + 1;
   localparam logic [FR_W-1:0] MAX_MAG = '1;

   // Dead zone registers.
   logic [DZ_W-1:0] dz_left_ff;
   logic [DZ_W-1:0] dz_right_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_left_ff  <= LEFT_DZ_RST;
         dz_right_ff <= RIGHT_DZ_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEFT_DZ:  dz_left_ff  <= csr_wdata;
            CSR_RIGHT_DZ: dz_right_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves together; it stalls only when the output
   // buffer is full.
   logic [1:0] cnt_ff;
   logic       en;

   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;

   // Stage 1: absolute values, signs and the selected dead zone.
   logic            v1_ff;
   logic [SB-1:0]   ax1_ff, ay1_ff;
   logic            sx1_ff, sy1_ff;
   logic [DZ_W-1:0] dz1_ff;
   logic [SB-1:0]   ux, uy;

   assign ux = req_raw_x;
   assign uy = req_raw_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
      if (en) begin
         ax1_ff <= ux[SB-1] ? (~ux + 1'b1) : ux;
         ay1_ff <= uy[SB-1] ? (~uy + 1'b1) : uy;
         sx1_ff <= ux[SB-1];
         sy1_ff <= uy[SB-1];
         dz1_ff <= req_stick_select ? dz_right_ff : dz_left_ff;
      end
   end

   // Stage 2: the two squares.
   logic            v2_ff;
   logic [SQ_W-1:0] sqx2_ff, sqy2_ff;
   logic [SB-1:0]   ax2_ff, ay2_ff;
   logic            sx2_ff, sy2_ff;
   logic [DZ_W-1:0] dz2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         sqx2_ff <= ax1_ff * ax1_ff;
         sqy2_ff <= ay1_ff * ay1_ff;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         sx2_ff  <= sx1_ff;
         sy2_ff  <= sy1_ff;
         dz2_ff  <= dz1_ff;
      end
   end

   // Stage 3: sum of squares; it never exceeds 2^(2*SB-1).
   logic              v3_ff;
   logic [SQ_W-1:0]   sum3_ff;
   logic [STAG_W-1:0] tag3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         sum3_ff <= sqx2_ff + sqy2_ff;
         tag3_ff <= {ax2_ff, ay2_ff, sx2_ff, sy2_ff, dz2_ff};
      end
   end

   // Square root.
   logic              sq_valid;
   logic [SB-1:0]     sq_root;
   logic [STAG_W-1:0] sq_tag;

   rsdz_sqrt #(
      .ROOT_W (SB),
      .TAG_W  (STAG_W)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (v3_ff),
      .in_radicand (sum3_ff),
      .in_tag      (tag3_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_tag     (sq_tag)
   );

   // Stage 4: dead zone test, clamp and rescale terms.
   logic [SB-1:0]   ax_s, ay_s;
   logic            sx_s, sy_s;
   logic [DZ_W-1:0] dz_s;
   logic [CMP_W-1:0] mag_c, dz_c, max_c;
   logic [FR_W-1:0] clamped;

   assign {ax_s, ay_s, sx_s, sy_s, dz_s} = sq_tag;
   assign mag_c   = CMP_W'(sq_root);
   assign dz_c    = CMP_W'(dz_s);
   assign max_c   = CMP_W'(MAX_MAG);
   assign clamped = (mag_c < max_c) ? FR_W'(sq_root) : MAX_MAG;

   logic            v4_ff;
   logic [FR_W-1:0] diff4_ff, span4_ff;
   logic [SB-1:0]   mag4_ff, ax4_ff, ay4_ff;
   logic            sx4_ff, sy4_ff, dead4_ff, full4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= sq_valid;
      end
      if (en) begin
         diff4_ff <= clamped - FR_W'(dz_s);
         span4_ff <= MAX_MAG - FR_W'(dz_s);
         mag4_ff  <= sq_root;
         ax4_ff   <= ax_s;
         ay4_ff   <= ay_s;
         sx4_ff   <= sx_s;
         sy4_ff   <= sy_s;
         dead4_ff <= (mag_c <= dz_c);
         full4_ff <= (dz_c >= max_c);
      end
   end

   // Stage 5: numerator products and the divisor.
   logic              v5_ff;
   logic [PROD_W-1:0] px5_ff, py5_ff, den5_ff;
   logic [DTAG_W-1:0] tag5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         px5_ff  <= ax4_ff * diff4_ff;
         py5_ff  <= ay4_ff * diff4_ff;
         den5_ff <= span4_ff * mag4_ff;
         tag5_ff <= {sx4_ff, sy4_ff, dead4_ff, full4_ff};
      end
   end

   // Stage 6: times full scale, as p * 2^FRAC_W - p.
   logic              v6_ff;
   logic [NUM_W-1:0]  nx6_ff, ny6_ff;
   logic [PROD_W-1:0] den6_ff;
   logic [DTAG_W-1:0] tag6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
      if (en) begin
         nx6_ff  <= (NUM_W'(px5_ff) << FRAC_W) - NUM_W'(px5_ff);
         ny6_ff  <= (NUM_W'(py5_ff) << FRAC_W) - NUM_W'(py5_ff);
         den6_ff <= den5_ff;
         tag6_ff <= tag5_ff;
      end
   end

   // Division. Since |raw| <= mag and clamped <= max, the quotient never
   // exceeds full scale, so no saturation stage is needed.
   logic              dv_valid;
   logic [FRAC_W-1:0] qx, qy;
   logic [DTAG_W-1:0] dv_tag;

   rsdz_div #(
      .NUM_W (NUM_W),
      .DEN_W (PROD_W),
      .TAG_W (DTAG_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6_ff),
      .in_num_a  (nx6_ff),
      .in_num_b  (ny6_ff),
      .in_den    (den6_ff),
      .in_tag    (tag6_ff),
      .out_valid (dv_valid),
      .out_quo_a (qx),
      .out_quo_b (qy),
      .out_tag   (dv_tag)
   );

   // Sign and dead zone handling; a dead zone at full range zeroes the axes.
   logic              sx_d, sy_d, dead_d, full_d, kill_d;
   logic [AXIS_W-1:0] ox, oy;
   logic [WORD_W-1:0] push_word;
   logic              push, pop;

   assign {sx_d, sy_d, dead_d, full_d} = dv_tag;
   assign kill_d = dead_d || full_d;
   assign ox = kill_d ? '0 : (sx_d ? (AXIS_W'(0) - AXIS_W'(qx)) : AXIS_W'(qx));
   assign oy = kill_d ? '0 : (sy_d ? (AXIS_W'(0) - AXIS_W'(qy)) : AXIS_W'(qy));
   assign push_word = {ox, oy, dead_d};

   // Two-beat output buffer: head_ff is presented, tail_ff holds the second.
   logic [WORD_W-1:0] head_ff, tail_ff;

   assign push = en && dv_valid;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      priority if (push && pop) begin
         if (cnt_ff == 2'd2) begin
            head_ff <= tail_ff;
            tail_ff <= push_word;
         end else begin
            head_ff <= push_word;
         end
      end else if (pop) begin
         head_ff <= tail_ff;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            head_ff <= push_word;
         end else begin
            tail_ff <= push_word;
         end
      end else begin
         // No beat moves, so the buffer holds its contents.
      end
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign {rsp_axis_x, rsp_axis_y, rsp_in_dead_zone} = head_ff;

   `RSDZ_ASSERT_IMPLY(a_dead_axes_zero, clock, reset, rsp_valid && rsp_in_dead_zone,
      rsp_axis_x == '0 && rsp_axis_y == '0)
   `RSDZ_ASSERT_IMPLY(a_axes_in_range, clock, reset, rsp_valid,
      rsp_axis_x != {1'b1, {(AXIS_W-1){1'b0}}} && rsp_axis_y != {1'b1, {(AXIS_W-1){1'b0}}})
   `RSDZ_ASSERT_NEVER(a_buffer_bound, clock, reset, cnt_ff == 2'd3)

endmodule

FILE: src/rsdz_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, restoring digit-by-digit; floor root of radicand.
// ----------------------------------------------------------------------------
module rsdz_sqrt #(
   parameter int ROOT_W = 16,
   parameter int TAG_W  = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [2*ROOT_W-1:0] in_radicand,
   input  logic [TAG_W-1:0]    in_tag,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output logic [TAG_W-1:0]    out_tag
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic              v_ff    [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [TAG_W-1:0]  tag_ff  [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic              v_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [TAG_W-1:0]  tag_prev;
      logic [REM_W-1:0]  cur;
      logic [REM_W-1:0]  trial;

      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rad_prev  = in_radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign tag_prev  = in_tag;
      end else begin : g_next
         assign v_prev    = v_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign tag_prev  = tag_ff[s-1];
      end

      // Bring down the next two radicand bits and try root*4 + 1.
      assign cur   = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_prev;
         end
         if (en) begin
            rad_ff[s] <= rad_prev << 2;
            tag_ff[s] <= tag_prev;
            if (cur >= trial) begin
               rem_ff[s]  <= cur - trial;
               root_ff[s] <= {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[s]  <= cur;
               root_ff[s] <= {root_prev[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

FILE: src/rsdz_div.sv
// ----------------------------------------------------------------------------
// Pipelined two-lane divider
// Restoring division of two numerators by one divisor, one quotient bit per
// stage; the quotient is known to fit in FRAC_W bits.
// ----------------------------------------------------------------------------
module rsdz_div
   import rsdz_pkg::*;
#(
   parameter int NUM_W = 46,
   parameter int DEN_W = 31,
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num_a,
   input  logic [NUM_W-1:0]  in_num_b,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [FRAC_W-1:0] out_quo_a,
   output logic [FRAC_W-1:0] out_quo_b,
   output logic [TAG_W-1:0]  out_tag
);

   logic              v_ff     [FRAC_W];
   logic [NUM_W-1:0]  rem_a_ff [FRAC_W];
   logic [NUM_W-1:0]  rem_b_ff [FRAC_W];
   logic [FRAC_W-1:0] quo_a_ff [FRAC_W];
   logic [FRAC_W-1:0] quo_b_ff [FRAC_W];
   logic [DEN_W-1:0]  den_ff   [FRAC_W];
   logic [TAG_W-1:0]  tag_ff   [FRAC_W];

   for (genvar s = 0; s < FRAC_W; s++) begin : g_stage
      logic              v_prev;
      logic [NUM_W-1:0]  rem_a_prev;
      logic [NUM_W-1:0]  rem_b_prev;
      logic [FRAC_W-1:0] quo_a_prev;
      logic [FRAC_W-1:0] quo_b_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [TAG_W-1:0]  tag_prev;
      logic [NUM_W:0]    den_sh;
      logic              ge_a;
      logic              ge_b;

      if (s == 0) begin : g_first
         assign v_prev     = in_valid;
         assign rem_a_prev = in_num_a;
         assign rem_b_prev = in_num_b;
         assign quo_a_prev = '0;
         assign quo_b_prev = '0;
         assign den_prev   = in_den;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign v_prev     = v_ff[s-1];
         assign rem_a_prev = rem_a_ff[s-1];
         assign rem_b_prev = rem_b_ff[s-1];
         assign quo_a_prev = quo_a_ff[s-1];
         assign quo_b_prev = quo_b_ff[s-1];
         assign den_prev   = den_ff[s-1];
         assign tag_prev   = tag_ff[s-1];
      end

      // Divisor aligned to the quotient bit that this stage decides.
      assign den_sh = (NUM_W + 1)'(den_prev) << (FRAC_W - 1 - s);
      assign ge_a   = {1'b0, rem_a_prev} >= den_sh;
      assign ge_b   = {1'b0, rem_b_prev} >= den_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_prev;
         end
         if (en) begin
            den_ff[s]   <= den_prev;
            tag_ff[s]   <= tag_prev;
            rem_a_ff[s] <= ge_a ? NUM_W'({1'b0, rem_a_prev} - den_sh) : rem_a_prev;
            rem_b_ff[s] <= ge_b ? NUM_W'({1'b0, rem_b_prev} - den_sh) : rem_b_prev;
            quo_a_ff[s] <= {quo_a_prev[FRAC_W-2:0], ge_a};
            quo_b_ff[s] <= {quo_b_prev[FRAC_W-2:0], ge_b};
         end
      end
   end

   assign out_valid = v_ff[FRAC_W-1];
   assign out_quo_a = quo_a_ff[FRAC_W-1];
   assign out_quo_b = quo_b_ff[FRAC_W-1];
   assign out_tag   = tag_ff[FRAC_W-1];

endmodule

FILE: tb/sv/radial_stick_dead_zone_top_tb.sv
// ----------------------------------------------------------------------------
// Radial stick dead zone testbench
// Drives stick sample beats through the block under several dead zone
// settings and flow-control patterns. Every result beat is checked against a
// predictor of the radial dead zone normalization, in order.
// ----------------------------------------------------------------------------
module radial_stick_dead_zone_top_tb
   import rsdz_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FULL_SCALE = 32767;
   localparam int MAX_MAG    = 32767;
   // Extra wait after the last result before the registers are written.
   localparam int DRAIN_CYCLES = 80;
   localparam int STALL_LIMIT  = 20000;

   // One normalized result.
   typedef struct packed {
      logic signed [AXIS_W-1:0] axis_x;
      logic signed [AXIS_W-1:0] axis_y;
      logic                     in_dz;
   } axis_beat_type;

   // One row of the directed table. When has_expect is set, the typed-in
   // result is compared with the predictor before the beat is sent.
   typedef struct {
      logic              stick;
      logic signed [15:0] x;
      logic signed [15:0] y;
      bit                has_expect;
      axis_beat_type     expect_val;
   } stick_row_type;

   logic clock;
   logic reset;
   logic req_valid, req_ready, req_stick_select;
   logic signed [15:0] req_raw_x, req_raw_y;
   logic rsp_valid, rsp_ready;
   logic signed [AXIS_W-1:0] rsp_axis_x, rsp_axis_y;
   logic rsp_in_dead_zone;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DZ_W-1:0] csr_wdata;

   radial_stick_dead_zone_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_stick_select(req_stick_select),
      .req_raw_x(req_raw_x), .req_raw_y(req_raw_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_axis_x(rsp_axis_x), .rsp_axis_y(rsp_axis_y),
      .rsp_in_dead_zone(rsp_in_dead_zone),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // The predictor keeps its own copy of both dead zone registers.
   logic [DZ_W-1:0] left_dz_shadow, right_dz_shadow;
   axis_beat_type expected_axes[$];
   int error_count;
   int samples_sent, results_seen, dead_zone_hits;
   // Percent chance per cycle that the sender idles or the receiver stalls.
   int send_idle_pct, recv_stall_pct;
   bit hold_off;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor square root by the digit-by-digit method.
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic signed [15:0] scale_axis(logic signed [15:0] raw,
      longint unsigned frac, longint unsigned den);
      longint unsigned mag_raw, q;
      mag_raw = (raw < 0) ? longint'(-int'(raw)) : longint'(raw);
      q = (mag_raw * frac * FULL_SCALE) / den;
      if (q > FULL_SCALE) q = FULL_SCALE;
      return (raw < 0) ? -16'(q) : 16'(q);
   endfunction

   function automatic axis_beat_type normalize_stick(logic stick, logic signed [15:0] x,
      logic signed [15:0] y);
      axis_beat_type r;
      longint unsigned dz, ax, ay, mag, clamped;
      dz = stick ? right_dz_shadow : left_dz_shadow;
      ax = (x < 0) ? longint'(-int'(x)) : longint'(x);
      ay = (y < 0) ? longint'(-int'(y)) : longint'(y);
      mag = floor_sqrt(ax * ax + ay * ay);
      r = '0;
      if (mag <= dz) begin
         r.in_dz = 1'b1;
      end else if (dz < MAX_MAG) begin
         clamped = (mag < MAX_MAG) ? mag : MAX_MAG;
         r.axis_x = scale_axis(x, clamped - dz, (MAX_MAG - dz) * mag);
         r.axis_y = scale_axis(y, clamped - dz, (MAX_MAG - dz) * mag);
      end
      return r;
   endfunction

   // Offer one sample beat and hold it until accepted. The predictor runs at
   // acceptance so that the queue order follows the wire. Valid stays high
   // after acceptance so that the next beat can follow at once; it drops
   // when the sender idles or when the sequence ends in wait_idle.
   task automatic send_sample(logic stick, logic signed [15:0] x, logic signed [15:0] y);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_stick_select <= stick;
      req_raw_x        <= x;
      req_raw_y        <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_axes.push_back(normalize_stick(stick, x, y));
      samples_sent++;
   endtask

   // Registers are written only once the pipeline has drained.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_axes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_dead_zone(csr_index_type idx, logic [DZ_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_LEFT_DZ) left_dz_shadow = value;
      else right_dz_shadow = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Biased sample value: extremes, near-zero values and full random.
   function automatic logic signed [15:0] pick_axis();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($signed($urandom_range(4000)) - 2000);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_samples(int count);
      repeat (count) send_sample(1'($urandom_range(1)), pick_axis(), pick_axis());
   endtask

   // Receiver: random stalls, plus a long hold-off when asked.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) rsp_ready <= 1'b0;
         else rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // Result checker, sampling at the clock edge.
   always @(posedge clock) begin
      axis_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_in_dead_zone) dead_zone_hits++;
         if (expected_axes.size() == 0) begin
            $error("result beat with nothing expected");
            error_count++;
         end else begin
            want = expected_axes.pop_front();
            if (rsp_axis_x !== want.axis_x) begin
               $error("axis_x expected %0d actual %0d", want.axis_x, rsp_axis_x);
               error_count++;
            end
            if (rsp_axis_y !== want.axis_y) begin
               $error("axis_y expected %0d actual %0d", want.axis_y, rsp_axis_y);
               error_count++;
            end
            if (rsp_in_dead_zone !== want.in_dz) begin
               $error("in_dead_zone expected %0d actual %0d", want.in_dz,
                      rsp_in_dead_zone);
               error_count++;
            end
         end
      end
   end

   // Watchdog: ends the run if no beat moves on any channel for too long.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready) || reset)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   stick_row_type directed[$];

   function automatic stick_row_type row(logic s, int x, int y, bit has = 0,
      int ex = 0, int ey = 0, logic edz = 0);
      stick_row_type r;
      r.stick = s;
      r.x = 16'(x);
      r.y = 16'(y);
      r.has_expect = has;
      r.expect_val.axis_x = 16'(ex);
      r.expect_val.axis_y = 16'(ey);
      r.expect_val.in_dz = edz;
      return r;
   endfunction

   initial begin
      axis_beat_type pred;
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_stick_select = 1'b0;
      req_raw_x = '0;
      req_raw_y = '0;
      csr_valid = 1'b0;
      csr_index = CSR_LEFT_DZ;
      csr_wdata = '0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      error_count = 0;
      samples_sent = 0;
      results_seen = 0;
      dead_zone_hits = 0;
      left_dz_shadow = LEFT_DZ_RST;
      right_dz_shadow = RIGHT_DZ_RST;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at the reset dead zones. Zero, small deflections and
      // the dead zone edges land in the dead zone; full deflection along an
      // axis reads as full scale, and the most negative value saturates.
      directed.push_back(row(0, 0, 0, 1, 0, 0, 1));
      directed.push_back(row(1, 0, 0, 1, 0, 0, 1));
      directed.push_back(row(0, 7849, 0, 1, 0, 0, 1));
      directed.push_back(row(0, 7850, 0));
      directed.push_back(row(1, 8689, 0, 1, 0, 0, 1));
      directed.push_back(row(1, 0, -8690));
      directed.push_back(row(0, 32767, 0, 1, 32767, 0, 0));
      directed.push_back(row(1, 0, 32767, 1, 0, 32767, 0));
      directed.push_back(row(0, -32768, 0, 1, -32767, 0, 0));
      directed.push_back(row(1, 0, -32768, 1, 0, -32767, 0));
      directed.push_back(row(0, -32768, -32768));
      directed.push_back(row(1, 32767, 32767));
      directed.push_back(row(0, 32767, -32768));
      directed.push_back(row(1, -1, 1, 1, 0, 0, 1));
      directed.push_back(row(0, 20000, 15000));
      directed.push_back(row(1, -12345, 23456));
      foreach (directed[i]) begin
         if (directed[i].has_expect) begin
            pred = normalize_stick(directed[i].stick, directed[i].x, directed[i].y);
            if (pred !== directed[i].expect_val) begin
               $error("directed row %0d: table and predictor disagree", i);
               error_count++;
            end
         end
         send_sample(directed[i].stick, directed[i].x, directed[i].y);
      end
      wait_idle();

      // Extreme dead zones: zero, just below the largest value, and the largest,
      // where every sample past the dead zone reads as zero without the flag.
      write_dead_zone(CSR_LEFT_DZ, 15'd0);
      write_dead_zone(CSR_RIGHT_DZ, 15'd32766);
      send_sample(0, 1, 0);
      send_sample(0, 0, -32768);
      send_sample(1, 32767, 0);
      send_sample(1, -32768, -32768);
      send_sample(1, 32766, 0);
      wait_idle();
      write_dead_zone(CSR_RIGHT_DZ, 15'h7fff);
      send_sample(1, -32768, 0);
      send_sample(1, 32767, 32767);
      wait_idle();

      // Random phases, each with its own dead zones and one of four flow-control mixes.
      for (phase = 0; phase < 5; phase++) begin
         write_dead_zone(CSR_LEFT_DZ, 15'($urandom_range(32766)));
         write_dead_zone(CSR_RIGHT_DZ, (phase == 4) ? 15'h7fff :
                                       15'($urandom_range(20000)));
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            3: begin send_idle_pct = 15; recv_stall_pct = 15; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         random_samples(140);
         wait_idle();
      end

      // Back pressure: the receiver holds off while the sender keeps
      // offering, so the pipeline fills and stalls the input.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         random_samples(80);
      join
      wait_idle();

      $display("Covered %0d sample beats, %0d results, %0d in the dead zone,",
               samples_sent, results_seen, dead_zone_hits);
      $display("over zero, full-scale and random dead zones with mixed back pressure.");
      if (error_count == 0 && expected_axes.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/rsdz_pkg.sv
src/rsdz_sqrt.sv
src/rsdz_div.sv
src/radial_stick_dead_zone_top.sv
tb/sv/radial_stick_dead_zone_top_tb.sv
